// ----- sv/dif_pkg.sv -----
// Shared types and constants for the decimal integer field formatter.
// No dependencies.
`default_nettype none
package dif_pkg;

  localparam int unsigned ValueW   = 64;
  localparam int unsigned CapAbs   = 64;   // hard cap on characters per field
  localparam int unsigned BndW     = 9;    // field boundary arithmetic width
  localparam int unsigned CycW     = 6;    // shift cycle counter

  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChZero  = 8'h30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_COUNT,
    ST_SETUP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic shift;
    logic count;
    logic setup;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic total_zero;
    logic pos_last;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- sv/dif_dp.sv -----
// Datapath: operand sizing, shift-and-add-3 binary to BCD, field layout and
// character output register. Depends on dif_pkg.
`default_nettype none
module dif_dp #(
  parameter int unsigned MAX_FIELD  = 64,
  parameter int unsigned MAX_DIGITS = 20
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire dif_pkg::dp_cmd_t     cmd_i,
  output dif_pkg::dp_status_t       status_o,
  input  wire logic [87:0]          in_data_i,
  input  wire logic [2:0]           in_user_i,
  output logic [7:0]                out_data_o,
  output logic                      out_last_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i
);
  import dif_pkg::*;

  localparam int unsigned Cap  = (MAX_FIELD < CapAbs) ? MAX_FIELD : CapAbs;
  localparam int unsigned CntW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IdxW = $clog2(MAX_DIGITS);

  logic [MAX_DIGITS-1:0][3:0] bcd_q, bcd_d;
  logic [ValueW-1:0] sh_q;
  logic ovf_q, magz_q;
  logic left_q, plus_q, space_q, zpad_q, hasp_q, sgn_q, neg_q;
  logic [6:0] width_q;
  logic [5:0] prec_q;
  logic [CntW-1:0] cnt_q;
  logic [BndW-1:0] b1_q, b2_q, b4_q, b5_q, total_q, pos_q;
  logic [7:0] sign_ch_q;
  logic [7:0] out_data_q;
  logic out_last_q, out_valid_q;

  // operand sizing
  logic [ValueW-1:0] v_in, mask, vm, mag;
  logic neg;
  always_comb begin
    v_in = in_data_i[63:0];
    unique case (in_user_i[2:1])
      2'd0:    mask = 64'h0000_0000_0000_00FF;
      2'd1:    mask = 64'h0000_0000_0000_FFFF;
      2'd2:    mask = 64'h0000_0000_FFFF_FFFF;
      default: mask = '1;
    endcase
    vm = v_in & mask;
    unique case (in_user_i[2:1])
      2'd0:    neg = in_user_i[0] & vm[7];
      2'd1:    neg = in_user_i[0] & vm[15];
      2'd2:    neg = in_user_i[0] & vm[31];
      default: neg = in_user_i[0] & vm[63];
    endcase
    mag = neg ? ((~vm + 64'd1) & mask) : vm;
  end

  // one shift-and-add-3 step
  logic [MAX_DIGITS-1:0][3:0] adj;
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
    end
    bcd_d = (4*MAX_DIGITS)'({adj, sh_q[ValueW-1]});
  end

  // significant digit count
  logic [CntW-1:0] cnt_calc;
  always_comb begin
    cnt_calc = CntW'(1);
    for (int i = 1; i < MAX_DIGITS; i++) begin
      if (bcd_q[i] != 4'd0) cnt_calc = CntW'(i + 1);
    end
    if (ovf_q) cnt_calc = CntW'(MAX_DIGITS);
    if (magz_q && hasp_q && prec_q == 6'd0) cnt_calc = '0;
  end

  // field layout
  logic [BndW-1:0] w_cl, sl, zeros, body, pad, b1, b2, b3, b4, b5, full;
  logic zp;
  always_comb begin
    w_cl  = (BndW'(width_q) > BndW'(Cap)) ? BndW'(Cap) : BndW'(width_q);
    sl    = BndW'(sign_ch_q != 8'd0);
    zeros = (hasp_q && BndW'(prec_q) > BndW'(cnt_q)) ? BndW'(prec_q) - BndW'(cnt_q) : '0;
    body  = sl + zeros + BndW'(cnt_q);
    pad   = (w_cl > body) ? w_cl - body : '0;
    zp    = zpad_q & ~left_q & ~hasp_q;
    b1    = (!left_q && !zp) ? pad : '0;
    b2    = b1 + sl;
    b3    = b2 + (zp ? pad : '0);
    b4    = b3 + zeros;
    b5    = b4 + BndW'(cnt_q);
    full  = b5 + (left_q ? pad : '0);
  end

  // character at current position
  logic [7:0] ch;
  logic [BndW-1:0] didx;
  always_comb begin
    didx = b5_q - BndW'(1) - pos_q;
    if (pos_q < b1_q)      ch = ChSpace;
    else if (pos_q < b2_q) ch = sign_ch_q;
    else if (pos_q < b4_q) ch = ChZero;
    else if (pos_q < b5_q) ch = ChZero + {4'd0, bcd_q[didx[IdxW-1:0]]};
    else                   ch = ChSpace;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      bcd_q   <= '0;
      sh_q    <= mag;
      ovf_q   <= 1'b0;
      magz_q  <= (mag == '0);
      sgn_q   <= in_user_i[0];
      neg_q   <= neg;
      left_q  <= in_data_i[64];
      plus_q  <= in_data_i[65];
      space_q <= in_data_i[66];
      zpad_q  <= in_data_i[67];
      width_q <= in_data_i[74:68];
      hasp_q  <= in_data_i[75];
      prec_q  <= in_data_i[81:76];
    end
    if (cmd_i.shift) begin
      bcd_q <= bcd_d;
      sh_q  <= sh_q << 1;
      ovf_q <= ovf_q | adj[MAX_DIGITS-1][3];
    end
    if (cmd_i.count) begin
      cnt_q <= cnt_calc;
      if (neg_q)                  sign_ch_q <= ChMinus;
      else if (sgn_q && plus_q)   sign_ch_q <= ChPlus;
      else if (sgn_q && space_q)  sign_ch_q <= ChSpace;
      else                        sign_ch_q <= 8'd0;
    end
    if (cmd_i.setup) begin
      b1_q    <= b1;
      b2_q    <= b2;
      b4_q    <= b4;
      b5_q    <= b5;
      total_q <= (full > BndW'(Cap)) ? BndW'(Cap) : full;
      pos_q   <= '0;
    end
    if (cmd_i.emit) begin
      out_data_q <= ch;
      out_last_q <= (pos_q == total_q - BndW'(1));
      pos_q      <= pos_q + BndW'(1);
    end
  end

  assign status_o.out_free   = ~out_valid_q | out_ready_i;
  assign status_o.total_zero = (total_q == '0);
  assign status_o.pos_last   = (pos_q == total_q - BndW'(1));
  assign out_data_o  = out_data_q;
  assign out_last_o  = out_last_q;
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ----- sv/dif_ctrl.sv -----
// Controller FSM: sequences load, 64 conversion shifts, count, layout and
// character emission. Depends on dif_pkg.
`default_nettype none
module dif_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output dif_pkg::dp_cmd_t         cmd_o,
  input  wire dif_pkg::dp_status_t status_i
);
  import dif_pkg::*;

  state_e state_q, state_d;
  logic [CycW-1:0] cyc_q, cyc_d;

  always_comb begin
    state_d = state_q;
    cyc_d   = cyc_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) begin
        state_d = ST_CONV;
        cyc_d   = '0;
      end
      ST_CONV: begin
        cyc_d = cyc_q + CycW'(1);
        if (cyc_q == '1) state_d = ST_COUNT;
      end
      ST_COUNT: state_d = ST_SETUP;
      ST_SETUP: state_d = ST_EMIT;
      ST_EMIT: begin
        if (status_i.total_zero) state_d = ST_IDLE;
        else if (status_i.out_free && status_i.pos_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CONV:  cmd_o.shift = 1'b1;
      ST_COUNT: cmd_o.count = 1'b1;
      ST_SETUP: cmd_o.setup = 1'b1;
      ST_EMIT:  cmd_o.emit = status_i.out_free & ~status_i.total_zero;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cyc_q   <= '0;
    end else begin
      state_q <= state_d;
      cyc_q   <= cyc_d;
    end
  end

  a_zero_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && status_i.total_zero) |=> state_q == ST_IDLE)
    else $error("empty field did not finish");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("emit into occupied output register");
  a_conv_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV && cyc_q != '1) |=> state_q == ST_CONV)
    else $error("conversion cut short");

endmodule
`default_nettype wire

// ----- sv/decimal_integer_field_formatter.sv -----
// Decimal integer field formatter, top level (printf %d/%i/%u).
// Depends on dif_pkg, dif_ctrl, dif_dp.
//
// Slave channel takes one conversion request per word; master channel gives
// one ASCII character per word, tlast on the final character of the field.
// A request runs: accept, shift-and-add-3 binary to BCD conversion of all 64
// value bits (one value bit per cycle), digit count, layout, then one
// character per cycle while the receiver takes them.
// Per request the field holds N output characters, N up to
// min(MAX_FIELD, 64); a field with no characters gives no word.
// The next request is accepted once the previous final character is loaded
// into the output register, even while that word waits.
// A stalled receiver holds the output word and pauses emission.
// Reset clears the controller and the output valid; the block is idle.
`default_nettype none
module decimal_integer_field_formatter #(
  parameter int unsigned MAX_FIELD  = 64,
  parameter int unsigned MAX_DIGITS = 20
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [63:0] value_bits, [64] left_justify, [65] force_plus, [66] space_sign,
  // [67] zero_pad, [74:68] field_width, [75] has_precision, [81:76] precision
  input  wire logic [87:0] s_axis_tdata,
  // [0] is_signed, [2:1] size_code
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] char_out
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast
);
  import dif_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dif_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  dif_dp #(
    .MAX_FIELD  (MAX_FIELD),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

endmodule
`default_nettype wire

// ----- tb/decimal_integer_field_formatter_test.sv -----
// Testbench for decimal_integer_field_formatter: drives conversion requests,
// predicts each formatted field in a local model and checks every character.
// Depends on dif_pkg and the formatter RTL.
`default_nettype none
module decimal_integer_field_formatter_test;
  import dif_pkg::*;

  typedef struct packed {
    logic [63:0] value_bits;
    logic        is_signed;
    logic [1:0]  size_code;
    logic        left_justify;
    logic        force_plus;
    logic        space_sign;
    logic        zero_pad;
    logic [6:0]  field_width;
    logic        has_precision;
    logic [5:0]  precision;
  } conv_req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_word_t;

  localparam int unsigned FieldCap = 64;
  localparam int unsigned DigitCap = 20;
  localparam int unsigned WatchLimit = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;

  conv_req_t  req_q[$];
  char_word_t chars_expected[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_req;
  int unsigned hold_cycles;
  bit          hold_taken;
  int unsigned quiet_cycles;
  bit          failed = 1'b0;

  decimal_integer_field_formatter dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [87:0] pack_data(conv_req_t r);
    logic [87:0] d;
    d = '0;
    d[63:0]  = r.value_bits;
    d[64]    = r.left_justify;
    d[65]    = r.force_plus;
    d[66]    = r.space_sign;
    d[67]    = r.zero_pad;
    d[74:68] = r.field_width;
    d[75]    = r.has_precision;
    d[81:76] = r.precision;
    return d;
  endfunction

  task automatic push_char(input logic [7:0] c, inout int unsigned n);
    char_word_t w;
    if (n < FieldCap) begin
      w.ch = c;
      w.last = 1'b0;
      chars_expected.push_back(w);
      n++;
    end
  endtask

  task automatic format_field(input conv_req_t r);
    logic [63:0] v, mask, mag;
    logic [3:0]  digs[DigitCap];
    logic [7:0]  sign_ch;
    int unsigned bits, ndig, width, zeros, body, pad, n, k;
    bit          neg, zp;
    char_word_t  w;
    bits = 8 << r.size_code;
    mask = (r.size_code == 2'd3) ? '1 : ((64'd1 << bits) - 1);
    width = (r.field_width > FieldCap) ? FieldCap : r.field_width;
    v = r.value_bits & mask;
    neg = r.is_signed && v[bits-1];
    mag = neg ? ((~v + 1) & mask) : v;
    ndig = 0;
    if (!(mag == 0 && r.has_precision && r.precision == 0)) begin
      do begin
        digs[ndig] = 4'(mag % 10);
        ndig++;
        mag = mag / 10;
      end while (mag != 0 && ndig < DigitCap);
    end
    if (neg) sign_ch = ChMinus;
    else if (r.is_signed && r.force_plus) sign_ch = ChPlus;
    else if (r.is_signed && r.space_sign) sign_ch = ChSpace;
    else sign_ch = 8'h00;
    zeros = (r.has_precision && r.precision > ndig) ? r.precision - ndig : 0;
    body = (sign_ch != 0) + zeros + ndig;
    pad = (width > body) ? width - body : 0;
    zp = r.zero_pad && !r.left_justify && !r.has_precision;
    n = 0;
    if (!r.left_justify && !zp) for (k = 0; k < pad; k++) push_char(ChSpace, n);
    if (sign_ch != 0) push_char(sign_ch, n);
    if (zp) for (k = 0; k < pad; k++) push_char(ChZero, n);
    for (k = 0; k < zeros; k++) push_char(ChZero, n);
    for (k = ndig; k > 0; k--) push_char(ChZero + digs[k-1], n);
    if (r.left_justify) for (k = 0; k < pad; k++) push_char(ChSpace, n);
    if (n > 0) begin
      w = chars_expected.pop_back();
      w.last = 1'b1;
      chars_expected.push_back(w);
    end
  endtask

  function automatic conv_req_t rand_req(bit wild);
    conv_req_t r;
    r = '0;
    r.value_bits = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: r.value_bits = 64'($urandom_range(0, 20));
      1: r.value_bits = -64'($urandom_range(0, 20));
      2: r.value_bits = {1'b1, 63'd0};
      default: ;
    endcase
    r.is_signed     = 1'($urandom_range(0, 1));
    r.size_code     = 2'($urandom_range(0, 3));
    r.left_justify  = 1'($urandom_range(0, 1));
    r.force_plus    = 1'($urandom_range(0, 1));
    r.space_sign    = 1'($urandom_range(0, 1));
    r.zero_pad      = 1'($urandom_range(0, 1));
    r.field_width   = wild ? 7'($urandom_range(0, 127)) : 7'($urandom_range(0, 24));
    r.has_precision = 1'($urandom_range(0, 1));
    r.precision     = wild ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 8));
    return r;
  endfunction

  function automatic conv_req_t mk(logic [63:0] v, bit sg, logic [1:0] sz,
                                   logic [3:0] flags, logic [6:0] w,
                                   bit hp, logic [5:0] p);
    conv_req_t r;
    r.value_bits = v;
    r.is_signed = sg;
    r.size_code = sz;
    {r.left_justify, r.force_plus, r.space_sign, r.zero_pad} = flags;
    r.field_width = w;
    r.has_precision = hp;
    r.precision = p;
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        format_field(req_q.pop_front());
      end
      if ((!s_axis_tvalid || s_axis_tready)) begin
        if (req_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pack_data(req_q[0]);
          s_axis_tuser  <= {req_q[0].size_code, req_q[0].is_signed};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver ready and monitor
  always @(posedge clk_i or negedge rst_ni) begin
    char_word_t w;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      quiet_cycles <= 0;
      hold_cycles <= 0;
      hold_taken <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (chars_expected.size() == 0) begin
          $display("%0t: unexpected word ch=%h last=%b", $time, m_axis_tdata, m_axis_tlast);
          failed = 1'b1;
        end else begin
          w = chars_expected.pop_front();
          if (w.ch !== m_axis_tdata || w.last !== m_axis_tlast) begin
            $display("%0t: mismatch expected ch=%h last=%b actual ch=%h last=%b",
                     $time, w.ch, w.last, m_axis_tdata, m_axis_tlast);
            failed = 1'b1;
          end
        end
      end
      if (hold_req != 0 && !hold_taken) begin
        hold_cycles <= hold_req;
        hold_taken <= 1'b1;
        m_axis_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= WatchLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic drain();
    while (req_q.size() != 0 || s_axis_tvalid || chars_expected.size() != 0)
      @(posedge clk_i);
  endtask

  initial begin
    int unsigned ph, k;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, flags, zero with zero precision, caps
    req_q.push_back(mk(64'd0, 1, 2, 4'b0000, 0, 1, 0));
    req_q.push_back(mk(64'd0, 1, 2, 4'b0100, 0, 1, 0));
    req_q.push_back(mk(64'd0, 0, 3, 4'b0110, 5, 1, 0));
    req_q.push_back(mk('1, 0, 3, 4'b0000, 0, 0, 0));
    req_q.push_back(mk('1, 1, 3, 4'b0000, 0, 0, 0));
    req_q.push_back(mk({1'b1, 63'd0}, 1, 3, 4'b0001, 30, 0, 0));
    req_q.push_back(mk(64'h80, 1, 0, 4'b0000, 0, 0, 0));
    req_q.push_back(mk(64'h8000, 1, 1, 4'b1000, 10, 0, 0));
    req_q.push_back(mk(64'h8000_0000, 1, 2, 4'b0001, 15, 0, 0));
    req_q.push_back(mk(64'h7F, 1, 0, 4'b0100, 6, 0, 0));
    req_q.push_back(mk(64'h7F, 1, 0, 4'b0010, 6, 0, 0));
    req_q.push_back(mk(64'h7F, 0, 0, 4'b0110, 6, 0, 0));
    req_q.push_back(mk(64'd42, 1, 2, 4'b1001, 8, 0, 0));
    req_q.push_back(mk(64'd42, 1, 2, 4'b0001, 8, 1, 4));
    req_q.push_back(mk(64'd42, 1, 2, 4'b0000, 127, 0, 0));
    req_q.push_back(mk(64'd42, 1, 2, 4'b1000, 64, 0, 0));
    req_q.push_back(mk(64'd7, 1, 3, 4'b0100, 70, 1, 63));
    req_q.push_back(mk('1, 1, 3, 4'b0001, 64, 0, 0));
    req_q.push_back(mk(64'hFF, 0, 0, 4'b0000, 0, 1, 1));
    drain();
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 31 : 87) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 31 : 87) : 0;
      if (ph == 0) hold_req = 600;
      for (k = 0; k < 55; k++) req_q.push_back(rand_req($urandom_range(0, 9) == 0));
      drain();
    end
    repeat (100) @(posedge clk_i);
    if (!failed && chars_expected.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

// ----- decimal_integer_field_formatter.f -----
sv/dif_pkg.sv
sv/dif_dp.sv
sv/dif_ctrl.sv
sv/decimal_integer_field_formatter.sv
tb/decimal_integer_field_formatter_test.sv
